// ===== design/b91le_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and digit split for the base-91 encoder
package b91le_pkg;

   localparam int ByteWidth   = 8;
   localparam int CharWidth   = 7;
   localparam int QueueWidth  = 12;
   localparam int CountWidth  = 4;
   localparam int GroupBits   = 13;
   localparam int ShortBits   = 6;
   localparam int WindowWidth = QueueWidth + ByteWidth;
   localparam int SumWidth    = CountWidth + 1;
   localparam int AlphaBase   = 91;
   localparam int CharOffset  = 33;
   localparam int CharMax     = AlphaBase - 1 + CharOffset;
   localparam int RecipMul    = 11523;
   localparam int RecipShift  = 20;
   localparam int RecipWidth  = 14;
   localparam int ProdWidth   = GroupBits + RecipWidth;
   localparam int IndexWidth  = 2;
   localparam int TotalWidth  = IndexWidth + 1;

   typedef enum logic [1:0] {
      FlushNone,
      FlushPair,
      FlushSingle
   } flush_kind_type;

   typedef struct packed {
      logic                  grp;
      logic [GroupBits-1:0]  grp_value;
      flush_kind_type        flush_kind;
      logic [GroupBits-1:0]  flush_value;
      logic                  last;
      logic [IndexWidth-1:0] last_idx;
   } job_type;

   typedef struct packed {
      logic [CharWidth-1:0] quot;
      logic [CharWidth-1:0] rem;
   } digits_type;

   // split v into v/91 and v%91 through a scaled reciprocal
   function automatic digits_type split_digits(input logic [GroupBits-1:0] v);
      logic [ProdWidth-1:0] prod;
      logic [GroupBits-1:0] back;
      logic [GroupBits-1:0] diff;
      digits_type           d;
      prod   = ProdWidth'(v) * ProdWidth'(RecipMul);
      d.quot = prod[RecipShift +: CharWidth];
      back   = GroupBits'(d.quot) * GroupBits'(AlphaBase);
      diff   = v - back;
      d.rem  = diff[CharWidth-1:0];
      return d;
   endfunction

endpackage

// ===== design/b91le_if.sv =====
`timescale 1ns / 1ps
// item channels for the base-91 encoder
interface b91le_req_if;
   logic                            valid;
   logic                            ready;
   logic [b91le_pkg::ByteWidth-1:0] data_byte;
   logic                            is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface b91le_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [b91le_pkg::CharWidth-1:0] out_char;
   logic                            run_last;
   logic                            message_end;

   modport source (output valid, output out_char, output run_last, output message_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input message_end,
                   output ready);
endinterface

// ===== design/base91_lazy_encoder.sv =====
`timescale 1ns / 1ps
// top level of the lazy base-91 encoder with fixed 13-bit groups
// One message byte per item; a byte that completes a 13-bit group gives two characters, so
// such bytes are bounded by the single result port that hands out one character a cycle
// while the receiver is ready. A last byte gives two to four characters (group pair plus
// flush). A byte is taken while the previous item's last character is moving out; its first
// character enters the result register when that is free. Bytes that give no character are
// taken every cycle while nothing is queued. Empty messages cannot be expressed.
module base91_lazy_encoder (
   input logic        clock,
   input logic        reset,
   b91le_req_if.sink  req_ch,
   b91le_rsp_if.source rsp_ch
);

   b91le_pkg::job_type job;
   logic               has_chars;
   logic               take;
   logic               accept;

   assign req_ch.ready = take;
   assign accept       = req_ch.valid && take;

   b91le_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_ch.data_byte),
      .is_last   (req_ch.is_last),
      .job       (job),
      .has_chars (has_chars)
   );

   b91le_emitter u_emitter (
      .clock           (clock),
      .reset           (reset),
      .load            (accept && has_chars),
      .new_job         (job),
      .take            (take),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_char        (rsp_ch.out_char),
      .rsp_run_last    (rsp_ch.run_last),
      .rsp_message_end (rsp_ch.message_end)
   );

endmodule

// ===== design/b91le_packer.sv =====
`timescale 1ns / 1ps
// bit queue: appends a byte, cuts a 13-bit group and plans the flush
module b91le_packer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [b91le_pkg::ByteWidth-1:0] data_byte,
   input  logic                            is_last,
   output b91le_pkg::job_type              job,
   output logic                            has_chars
);

   logic [b91le_pkg::QueueWidth-1:0]  pend_ff, pend_in;
   logic [b91le_pkg::CountWidth-1:0]  cnt_ff, cnt_in;
   logic [b91le_pkg::CountWidth-1:0]  shamt;
   logic [b91le_pkg::WindowWidth-1:0] window, rest;
   logic [b91le_pkg::SumWidth-1:0]    sum_cnt, rest_cnt;
   logic [b91le_pkg::TotalWidth-1:0]  total;
   logic                              grp;

   always_comb begin
      shamt   = b91le_pkg::CountWidth'(b91le_pkg::QueueWidth) - cnt_ff;
      window  = {pend_ff, b91le_pkg::ByteWidth'(0)}
              | (b91le_pkg::WindowWidth'(data_byte) << shamt);
      sum_cnt = {1'b0, cnt_ff} + b91le_pkg::SumWidth'(b91le_pkg::ByteWidth);
      grp     = sum_cnt > b91le_pkg::SumWidth'(b91le_pkg::QueueWidth);
      if (grp) begin
         rest     = window << b91le_pkg::GroupBits;
         rest_cnt = sum_cnt - b91le_pkg::SumWidth'(b91le_pkg::GroupBits);
      end else begin
         rest     = window;
         rest_cnt = sum_cnt;
      end

      job.grp         = grp;
      job.grp_value   = window[b91le_pkg::WindowWidth-1 -: b91le_pkg::GroupBits];
      job.flush_value = rest[b91le_pkg::WindowWidth-1 -: b91le_pkg::GroupBits];
      job.last        = is_last;
      if (!is_last) begin
         job.flush_kind = b91le_pkg::FlushNone;
      end else if (rest_cnt > b91le_pkg::SumWidth'(b91le_pkg::ShortBits)) begin
         job.flush_kind = b91le_pkg::FlushPair;
      end else if (rest_cnt != '0) begin
         job.flush_kind = b91le_pkg::FlushSingle;
      end else begin
         job.flush_kind = b91le_pkg::FlushNone;
      end

      total = grp ? b91le_pkg::TotalWidth'(2) : '0;
      if (job.flush_kind == b91le_pkg::FlushPair) begin
         total = total + b91le_pkg::TotalWidth'(2);
      end else if (job.flush_kind == b91le_pkg::FlushSingle) begin
         total = total + b91le_pkg::TotalWidth'(1);
      end
      has_chars    = total != '0;
      job.last_idx = b91le_pkg::IndexWidth'(total - b91le_pkg::TotalWidth'(1));

      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         if (is_last) begin
            pend_in = '0;
            cnt_in  = '0;
         end else begin
            pend_in = rest[b91le_pkg::WindowWidth-1 -: b91le_pkg::QueueWidth];
            cnt_in  = rest_cnt[b91le_pkg::CountWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== design/b91le_emitter.sv =====
`timescale 1ns / 1ps
// holds one item's characters; the result register gives one a cycle unless stalled
module b91le_emitter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  b91le_pkg::job_type              new_job,
   output logic                            take,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [b91le_pkg::CharWidth-1:0] rsp_char,
   output logic                            rsp_run_last,
   output logic                            rsp_message_end
);

   b91le_pkg::job_type               job_ff, job_in;
   logic                             job_valid_ff, job_valid_in;
   logic [b91le_pkg::IndexWidth-1:0] idx_ff, idx_in;
   logic                             out_valid_ff, out_valid_in;
   logic [b91le_pkg::CharWidth-1:0]  char_ff, char_in;
   logic                             run_last_ff, run_last_in;
   logic                             msg_end_ff, msg_end_in;
   logic                             out_free, advance, finish, in_flush, hi;
   logic [b91le_pkg::GroupBits-1:0]  value;
   b91le_pkg::digits_type            digits;

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      advance  = job_valid_ff && out_free;
      finish   = advance && (idx_ff == job_ff.last_idx);
      take     = !job_valid_ff || finish;

      // pairs sit at even positions, quotient first
      in_flush = !job_ff.grp || idx_ff[1];
      hi       = !idx_ff[0];
      value    = in_flush ? job_ff.flush_value : job_ff.grp_value;
      digits   = b91le_pkg::split_digits(value);

      if (in_flush && job_ff.flush_kind == b91le_pkg::FlushSingle) begin
         char_in = b91le_pkg::CharWidth'(value[b91le_pkg::GroupBits-1 -: b91le_pkg::ShortBits])
                 + b91le_pkg::CharWidth'(b91le_pkg::CharOffset);
      end else if (hi) begin
         char_in = digits.quot + b91le_pkg::CharWidth'(b91le_pkg::CharOffset);
      end else begin
         char_in = digits.rem + b91le_pkg::CharWidth'(b91le_pkg::CharOffset);
      end
      run_last_in = idx_ff == job_ff.last_idx;
      msg_end_in  = run_last_in && job_ff.last;

      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         job_in       = new_job;
         job_valid_in = 1'b1;
         idx_in       = '0;
      end else if (finish) begin
         job_valid_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + b91le_pkg::IndexWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (advance) begin
         char_ff     <= char_in;
         run_last_ff <= run_last_in;
         msg_end_ff  <= msg_end_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_char        = char_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_message_end = msg_end_ff;

`ifndef SYNTHESIS
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (char_ff >= b91le_pkg::CharWidth'(b91le_pkg::CharOffset)
                     && char_ff <= b91le_pkg::CharWidth'(b91le_pkg::CharMax)))
      else $error("result character outside the alphabet");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> idx_ff <= job_ff.last_idx)
      else $error("character index ran past the item's last character");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && msg_end_ff) |-> run_last_ff)
      else $error("message end without run end");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!job_valid_ff || finish))
      else $error("new item loaded over unfinished characters");
   a_output_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(char_ff)))
      else $error("stalled result character changed");
`endif

endmodule

// ===== bench/base91_lazy_encoder_tb.sv =====
`timescale 1ns / 1ps
// testbench for the lazy base-91 encoder: directed flush cases, random messages, long stall
module base91_lazy_encoder_tb;

   localparam int ClockPeriod = 10;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 20;
   localparam int RandomItems = 290;

   typedef enum int {
      RxAlways,
      RxRandom,
      RxPattern
   } rx_mode_type;

   typedef struct packed {
      logic [b91le_pkg::CharWidth-1:0] ch;
      logic                            run_last;
      logic                            message_end;
   } encoded_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b91le_req_if req_ch ();
   b91le_rsp_if rsp_ch ();

   base91_lazy_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // predictor state
   logic [b91le_pkg::QueueWidth-1:0] queued_bits  = '0;
   int unsigned                      queued_count = 0;
   encoded_char_type                 expected_chars[$];

   // counters
   int error_count    = 0;
   int bytes_accepted = 0;
   int messages_done  = 0;
   int chars_checked  = 0;
   int long_stalls    = 0;
   int cycle_count    = 0;

   // sender pacing
   int send_max_gap  = 0;
   int send_max_run  = 8;
   int burst_left    = 0;

   // receiver pacing
   rx_mode_type rx_mode     = RxAlways;
   int          rx_period   = 3;
   int          rx_phase    = 0;
   int          hold_cycles = 0;
   logic        holding     = 1'b0;

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.is_last   = 1'b0;
      rsp_ch.ready     = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic push_char(input int value);
      encoded_char_type c;
      c.ch          = b91le_pkg::CharWidth'(value + b91le_pkg::CharOffset);
      c.run_last    = 1'b0;
      c.message_end = 1'b0;
      expected_chars.push_back(c);
   endtask

   task automatic push_group(input logic [b91le_pkg::GroupBits-1:0] v);
      push_char(int'(v) / b91le_pkg::AlphaBase);
      push_char(int'(v) % b91le_pkg::AlphaBase);
   endtask

   // model of the bit queue and the characters one byte gives
   task automatic predict_chars(input logic [b91le_pkg::ByteWidth-1:0] data_in,
                                input logic last);
      logic [31:0]      window;
      int unsigned      count;
      int               size_before;
      encoded_char_type tail;
      window      = {queued_bits, 20'b0};
      count       = queued_count;
      size_before = expected_chars.size();
      window      = window | (32'(data_in) << (24 - count));
      count       = count + b91le_pkg::ByteWidth;
      if (count > b91le_pkg::QueueWidth) begin
         push_group(window[31 -: b91le_pkg::GroupBits]);
         window = window << b91le_pkg::GroupBits;
         count  = count - b91le_pkg::GroupBits;
      end
      if (last) begin
         if (count > b91le_pkg::ShortBits) begin
            push_group(window[31 -: b91le_pkg::GroupBits]);
         end else if (count > 0) begin
            push_char(int'(window[31 -: b91le_pkg::ShortBits]));
         end
         window = '0;
         count  = 0;
         messages_done++;
      end
      queued_bits  = window[31 -: b91le_pkg::QueueWidth];
      queued_count = count;
      if (expected_chars.size() > size_before) begin
         tail             = expected_chars.pop_back();
         tail.run_last    = 1'b1;
         tail.message_end = last;
         expected_chars.push_back(tail);
      end
   endtask

   // accepted items on both channels
   always @(posedge clock) begin
      encoded_char_type want;
      if (!reset && req_ch.valid && req_ch.ready) begin
         bytes_accepted++;
         predict_chars(req_ch.data_byte, req_ch.is_last);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", int'(rsp_ch.out_char), 0);
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_ch.out_char !== want.ch)
               report_mismatch("out_char", int'(rsp_ch.out_char), int'(want.ch));
            if (rsp_ch.run_last !== want.run_last)
               report_mismatch("run_last", int'(rsp_ch.run_last), int'(want.run_last));
            if (rsp_ch.message_end !== want.message_end)
               report_mismatch("message_end", int'(rsp_ch.message_end),
                               int'(want.message_end));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
                  expected_chars.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // long receiver hold-off
   always begin
      int hold_len;
      @(negedge clock);
      if (hold_cycles != 0) begin
         hold_len    = hold_cycles;
         hold_cycles = 0;
         long_stalls++;
         holding <= 1'b1;
         repeat (hold_len) @(negedge clock);
         holding <= 1'b0;
      end
   end

   always @(negedge clock) begin
      logic take;
      case (rx_mode)
         RxAlways: begin
            take = 1'b1;
         end
         RxRandom: begin
            take = ($urandom_range(0, 99) < 60);
         end
         default: begin
            take = (rx_phase % rx_period) != 0;
         end
      endcase
      rx_phase++;
      rsp_ch.ready <= take && !holding;
   end

   task automatic send_byte(input logic [b91le_pkg::ByteWidth-1:0] data_in, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, send_max_run);
         gap        = $urandom_range(0, send_max_gap);
         if (gap != 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data_in;
      req_ch.is_last   <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   function automatic logic [b91le_pkg::ByteWidth-1:0] random_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return b91le_pkg::ByteWidth'($urandom_range(0, 255));
   endfunction

   task automatic send_message(input int length);
      for (int i = 0; i < length; i++)
         send_byte(random_byte(), i == length - 1);
   endtask

   // one byte: eight bits left, flushed as a pair
   task automatic test_single_byte_message();
      send_byte(8'h00, 1'b1);
   endtask

   // group from two bytes, then three bits flushed as one character
   task automatic test_short_flush();
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
   endtask

   // thirteen bytes leave nothing queued, so the group pair ends the message
   task automatic test_exact_group_end();
      for (int i = 0; i < 13; i++)
         send_byte((i % 2 == 0) ? 8'hff : 8'h00, i == 12);
   endtask

   // nine bytes: group pair plus a flushed pair on the last byte
   task automatic test_four_char_flush();
      logic [b91le_pkg::ByteWidth-1:0] pattern [9] = '{8'h80, 8'h01, 8'h7f, 8'hfe, 8'h55,
                                                       8'haa, 8'hff, 8'h00, 8'hff};
      for (int i = 0; i < 9; i++)
         send_byte(pattern[i], i == 8);
   endtask

   task automatic test_random_messages(input int items);
      int sent;
      int length;
      int phase;
      sent = 0;
      while (sent < items) begin
         phase = $urandom_range(0, 3);
         case (phase)
            0: begin
               rx_mode      = RxAlways;
               send_max_gap = 0;
            end
            1: begin
               rx_mode      = RxRandom;
               send_max_gap = 6;
            end
            2: begin
               rx_mode      = RxPattern;
               rx_period    = $urandom_range(2, 5);
               send_max_gap = 3;
            end
            default: begin
               rx_mode      = RxRandom;
               send_max_gap = 0;
            end
         endcase
         length = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 32)
                                              : $urandom_range(1, 16);
         send_message(length);
         sent += length;
      end
   endtask

   // receiver holds off while the sender keeps offering bytes
   task automatic test_backpressure_hold();
      rx_mode      = RxAlways;
      send_max_gap = 0;
      hold_cycles  = 200;
      send_message(40);
      send_message(3);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_byte_message();
      test_short_flush();
      test_exact_group_end();
      test_four_char_flush();
      test_backpressure_hold();
      test_random_messages(RandomItems);
      stop_sending();

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d messages, %0d bytes, %0d characters checked", messages_done,
               bytes_accepted, chars_checked);
      $display("with %0d long receiver stall(s) and %0d mismatch(es)", long_stalls,
               error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
